// ===== sv/lfe_pkg.sv =====
// shared types, widths and constants of the led fade envelope
package lfe_pkg;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int LVL_W     = 16;
    localparam int HUE_W     = 16;
    localparam int LED_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int DIV_STEPS = FRAC_W;

    // unity fraction in unsigned q0.16, held on 17 bits
    localparam logic [FRAC_W:0] FRAC_ONE = 17'h1_0000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LED    = 3'd6;

    // reset values of the configuration registers
    localparam logic [MS_W-1:0]  OFFSET_RST = 16'd0;
    localparam logic [MS_W-1:0]  RISE_RST   = 16'd400;
    localparam logic [MS_W-1:0]  HOLD_RST   = 16'd400;
    localparam logic [MS_W-1:0]  FALL_RST   = 16'd400;
    localparam logic [LVL_W-1:0] PEAK_RST   = 16'h8000;
    localparam logic [HUE_W-1:0] HUE_RST    = 16'd0;
    localparam logic [LED_W-1:0] LED_RST    = 8'd0;

    typedef enum logic [1:0] {
        PH_RISE,
        PH_HOLD,
        PH_FALL,
        PH_DONE
    } phase_t;

    // timing registers seen by the front end
    typedef struct packed {
        logic [MS_W-1:0] offset;
        logic [MS_W-1:0] rise;
        logic [MS_W-1:0] hold;
        logic [MS_W-1:0] fall;
    } env_cfg_t;

    // item travelling down the divider chain
    typedef struct packed {
        phase_t            phase;
        logic              fin;
        logic [MS_W-1:0]   den;
        logic [MS_W-1:0]   rem;
        logic [FRAC_W-1:0] quo;
    } div_item_t;

endpackage

// ===== sv/led_fade_envelope.sv =====
// top level: quadratic rise, hold and fall brightness envelope for one led
// pipeline: 2 front stages, 16 divider cells at one quotient bit each, square stage,
//   output register
// throughput: one item per cycle while out_stall is low; every stage forwards as soon as its successor frees
// items before the offset are taken and give no result
// reset: asynchronous active low; clears all valid bits and the finished flag,
//   configuration returns to offset 0, 400 ms phases, peak 0x8000, hue 0, led 0
module led_fade_envelope
    import lfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    elapsed_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LED_W-1:0]     out_led,
    output logic [HUE_W-1:0]     out_hue,
    output logic [LVL_W-1:0]     out_level,
    output logic                 finished
);

    env_cfg_t         cfg_reg, cfg_next;
    logic [LVL_W-1:0] peak_reg, peak_next;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [LED_W-1:0] led_reg, led_next;

    logic      front_ready;
    logic      chain_valid [DIV_STEPS+1];
    logic      chain_ready [DIV_STEPS+1];
    div_item_t chain_item  [DIV_STEPS+1];

    // configuration register writes
    always_comb
    begin
        cfg_next  = cfg_reg;
        peak_next = peak_reg;
        hue_next  = hue_reg;
        led_next  = led_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET: cfg_next.offset = cfg_data;
                CFG_RISE:   cfg_next.rise   = cfg_data;
                CFG_HOLD:   cfg_next.hold   = cfg_data;
                CFG_FALL:   cfg_next.fall   = cfg_data;
                CFG_PEAK:   peak_next       = cfg_data;
                CFG_HUE:    hue_next        = cfg_data;
                CFG_LED:    led_next        = cfg_data[LED_W-1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset <= OFFSET_RST;
            cfg_reg.rise   <= RISE_RST;
            cfg_reg.hold   <= HOLD_RST;
            cfg_reg.fall   <= FALL_RST;
            peak_reg       <= PEAK_RST;
            hue_reg        <= HUE_RST;
            led_reg        <= LED_RST;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            peak_reg <= peak_next;
            hue_reg  <= hue_next;
            led_reg  <= led_next;
        end
    end

    // offset and phase front end
    lfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (in_valid),
        .up_ready (front_ready),
        .elapsed  (elapsed_ms),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_item  (chain_item[0])
    );

    assign in_stall = !front_ready;

    // divider chain, one quotient bit per cell
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        lfe_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_item  (chain_item[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_item  (chain_item[i+1])
        );
    end

    // squaring, scaling and output register
    lfe_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .peak      (peak_reg),
        .up_valid  (chain_valid[DIV_STEPS]),
        .up_ready  (chain_ready[DIV_STEPS]),
        .up_item   (chain_item[DIV_STEPS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (out_level),
        .fin       (finished)
    );

    // the user must keep led and hue static while items are in flight; the block itself does not enforce it
    assign out_led = led_reg;
    assign out_hue = hue_reg;

endmodule

// ===== sv/lfe_front.sv =====
// front end: offset subtract, phase decision and sticky finished flag
module lfe_front
    import lfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  env_cfg_t          cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [TIME_W-1:0] elapsed,
    output logic              dn_valid,
    input  logic              dn_ready,
    output div_item_t         dn_item
);

    logic              a_valid_reg, a_valid_next;
    logic [TIME_W-1:0] a_t_reg, a_t_next;
    logic              b_valid_reg, b_valid_next;
    div_item_t         b_item_reg, b_item_next;
    logic              done_reg, done_next;

    logic              a_ready, b_ready;
    logic [TIME_W:0]   off_diff;
    logic [TIME_W:0]   rise_diff;
    logic [TIME_W:0]   fall_diff;
    logic [MS_W:0]     rh_sum;
    phase_t            phase;
    logic [MS_W-1:0]   num;
    logic [MS_W-1:0]   den;

    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    // stage a: time since offset, items before the offset are dropped
    always_comb
    begin
        off_diff     = {1'b0, elapsed} - {{(TIME_W-MS_W+1){1'b0}}, cfg.offset};
        a_valid_next = a_valid_reg;
        a_t_next     = a_t_reg;
        if (a_ready)
        begin
            a_valid_next = up_valid && !off_diff[TIME_W];
            a_t_next     = off_diff[TIME_W-1:0];
        end
    end

    // stage b: phase decision and divider operands
    always_comb
    begin
        rh_sum    = {1'b0, cfg.rise} + {1'b0, cfg.hold};
        rise_diff = {1'b0, a_t_reg} - {{(TIME_W-MS_W+1){1'b0}}, cfg.rise};
        fall_diff = {1'b0, a_t_reg} - {{(TIME_W-MS_W){1'b0}}, rh_sum};
        num       = '0;
        den       = cfg.rise;
        if (rise_diff[TIME_W])
        begin
            phase = PH_RISE;
            num   = a_t_reg[MS_W-1:0];
        end
        else if (fall_diff[TIME_W])
        begin
            phase = PH_HOLD;
        end
        else if (fall_diff[TIME_W-1:MS_W] == '0 && fall_diff[MS_W-1:0] < cfg.fall)
        begin
            phase = PH_FALL;
            num   = fall_diff[MS_W-1:0];
            den   = cfg.fall;
        end
        else
        begin
            phase = PH_DONE;
        end

        b_valid_next = b_valid_reg;
        b_item_next  = b_item_reg;
        done_next    = done_reg;
        if (b_ready)
        begin
            b_valid_next      = a_valid_reg;
            b_item_next.phase = phase;
            b_item_next.fin   = done_reg || (phase == PH_DONE);
            b_item_next.den   = den;
            b_item_next.rem   = num;
            b_item_next.quo   = '0;
            done_next         = done_reg || (a_valid_reg && phase == PH_DONE);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_t_reg    <= a_t_next;
        b_item_reg <= b_item_next;
    end

    assign dn_valid = b_valid_reg;
    assign dn_item  = b_item_reg;

endmodule

// ===== sv/lfe_div_cell.sv =====
// one restoring division cell: produces one quotient bit per item
module lfe_div_cell
    import lfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  div_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_item_t dn_item
);

    logic          valid_reg, valid_next;
    div_item_t     item_reg, item_next;
    logic [MS_W:0] rem_dbl;
    logic [MS_W:0] rem_sub;

    assign up_ready = !valid_reg || dn_ready;

    // shift remainder left, subtract divisor when it fits
    always_comb
    begin
        rem_dbl    = {up_item.rem, 1'b0};
        rem_sub    = rem_dbl - {1'b0, up_item.den};
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            item_next  = up_item;
            if (rem_dbl >= {1'b0, up_item.den})
            begin
                item_next.rem = rem_sub[MS_W-1:0];
                item_next.quo = {up_item.quo[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                item_next.rem = rem_dbl[MS_W-1:0];
                item_next.quo = {up_item.quo[FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ===== sv/lfe_scale.sv =====
// back end: fraction select, squaring and peak scaling into the output register
module lfe_scale
    import lfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LVL_W-1:0] peak,
    input  logic             up_valid,
    output logic             up_ready,
    input  div_item_t        up_item,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [LVL_W-1:0] level,
    output logic             fin
);

    logic                s_valid_reg, s_valid_next;
    logic [FRAC_W:0]     s_sq_reg, s_sq_next;
    logic                s_fin_reg, s_fin_next;
    logic                o_valid_reg, o_valid_next;
    logic [LVL_W-1:0]    o_level_reg, o_level_next;
    logic                o_fin_reg, o_fin_next;

    logic                o_ready, s_ready;
    logic [FRAC_W:0]     frac;
    logic [2*FRAC_W+1:0] sq_prod;
    logic [LVL_W+FRAC_W:0] lvl_prod;

    assign o_ready  = !o_valid_reg || !out_stall;
    assign s_ready  = !s_valid_reg || o_ready;
    assign up_ready = s_ready;

    // fraction per phase, then its square in q0.16
    always_comb
    begin
        case (up_item.phase)
            PH_RISE: frac = {1'b0, up_item.quo};
            PH_HOLD: frac = FRAC_ONE;
            PH_FALL: frac = FRAC_ONE - {1'b0, up_item.quo};
            default: frac = '0;
        endcase
        sq_prod      = frac * frac;
        s_valid_next = s_valid_reg;
        s_sq_next    = s_sq_reg;
        s_fin_next   = s_fin_reg;
        if (s_ready)
        begin
            s_valid_next = up_valid;
            s_sq_next    = sq_prod[2*FRAC_W:FRAC_W];
            s_fin_next   = up_item.fin;
        end
    end

    // peak times squared fraction
    always_comb
    begin
        lvl_prod     = peak * s_sq_reg;
        o_valid_next = o_valid_reg;
        o_level_next = o_level_reg;
        o_fin_next   = o_fin_reg;
        if (o_ready)
        begin
            o_valid_next = s_valid_reg;
            o_level_next = lvl_prod[LVL_W+FRAC_W-1:FRAC_W];
            o_fin_next   = s_fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_sq_reg    <= s_sq_next;
        s_fin_reg   <= s_fin_next;
        o_level_reg <= o_level_next;
        o_fin_reg   <= o_fin_next;
    end

    assign out_valid = o_valid_reg;
    assign level     = o_level_reg;
    assign fin       = o_fin_reg;

endmodule

// ===== sv/lfe_checker.sv =====
// port-level checks of the led fade envelope, bound to the top level
module lfe_checker
    import lfe_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [LVL_W-1:0] out_level,
    input logic             finished
);

    // a stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_level) && $stable(finished))
        else $error("stalled result changed");

    // no result while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result during reset");

    // input backs up only when the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    // finished flag is sticky from one shown result to the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |=> !out_valid || finished)
        else $error("finished flag dropped");

    // a shown result before the finish carries a known level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished |-> !$isunknown(out_level))
        else $error("unknown level on result");

endmodule

bind led_fade_envelope lfe_checker u_lfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level),
    .finished  (finished)
);

// ===== tb/sv/led_fade_envelope_test.sv =====
`timescale 1ns / 1ps
// testbench of the led fade envelope: level predictor, scoreboard and item drivers
module led_fade_envelope_test;
    import lfe_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int RESET_CYCLES    = 6;
    localparam int DRAIN_CYCLES    = 32;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 200;

    // one led write as it leaves the block
    typedef struct packed {
        logic [LED_W-1:0] led;
        logic [HUE_W-1:0] hue;
        logic [LVL_W-1:0] level;
        logic             fin;
    } led_write_t;

    // envelope predictor and in-order store of the led writes still due
    class envelope_scoreboard;
        logic [MS_W-1:0]  offset_ms;
        logic [MS_W-1:0]  rise_ms;
        logic [MS_W-1:0]  hold_ms;
        logic [MS_W-1:0]  fall_ms;
        logic [LVL_W-1:0] peak;
        logic [HUE_W-1:0] hue;
        logic [LED_W-1:0] led;
        logic             done;
        led_write_t       writes_due[$];
        int unsigned      fails;

        function new();
            offset_ms = OFFSET_RST;
            rise_ms   = RISE_RST;
            hold_ms   = HOLD_RST;
            fall_ms   = FALL_RST;
            peak      = PEAK_RST;
            hue       = HUE_RST;
            led       = LED_RST;
            done      = 1'b0;
            fails     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_OFFSET: offset_ms = data;
                CFG_RISE:   rise_ms   = data;
                CFG_HOLD:   hold_ms   = data;
                CFG_FALL:   fall_ms   = data;
                CFG_PEAK:   peak      = data;
                CFG_HUE:    hue       = data;
                CFG_LED:    led       = data[LED_W-1:0];
                default:    ;
            endcase
        endfunction

        // peak scaled by the square of a q0.16 fraction, 1.0 included
        function logic [LVL_W-1:0] peak_by_square(logic [FRAC_W:0] frac);
            logic [63:0] f;
            logic [63:0] sq;
            logic [63:0] lvl;
            f   = {{(63-FRAC_W){1'b0}}, frac};
            sq  = (f * f) >> 16;
            lvl = ({48'd0, peak} * sq) >> 16;
            return lvl[LVL_W-1:0];
        endfunction

        function void note_item(logic [TIME_W-1:0] now);
            logic [63:0] t;
            logic [63:0] d;
            logic [63:0] q;
            led_write_t  w;
            // before the offset nothing is written
            if (now < offset_ms)
                return;
            t = {32'd0, now} - {48'd0, offset_ms};
            if (t < rise_ms) begin
                q = (t << 16) / rise_ms;
                w.level = peak_by_square(q[FRAC_W:0]);
            end
            else if (t - rise_ms < hold_ms) begin
                w.level = peak;
            end
            else if (t - rise_ms - hold_ms < fall_ms) begin
                d = t - rise_ms - hold_ms;
                q = FRAC_ONE - ((d << 16) / fall_ms);
                w.level = peak_by_square(q[FRAC_W:0]);
            end
            else begin
                done = 1'b1;
                w.level = '0;
            end
            w.led = led;
            w.hue = hue;
            w.fin = done;
            writes_due.push_back(w);
        endfunction

        function void check_result(led_write_t got);
            led_write_t want;
            if (writes_due.size() == 0) begin
                $error("led write with none due: led %0d hue %0d level %0d finished %0d",
                       got.led, got.hue, got.level, got.fin);
                fails++;
                return;
            end
            want = writes_due.pop_front();
            if (got.led !== want.led) begin
                $error("out_led: expected %0d, got %0d", want.led, got.led);
                fails++;
            end
            if (got.hue !== want.hue) begin
                $error("out_hue: expected %0d, got %0d", want.hue, got.hue);
                fails++;
            end
            if (got.level !== want.level) begin
                $error("out_level: expected %0d, got %0d", want.level, got.level);
                fails++;
            end
            if (got.fin !== want.fin) begin
                $error("finished: expected %0d, got %0d", want.fin, got.fin);
                fails++;
            end
        endfunction

        function int pending();
            return writes_due.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [TIME_W-1:0]    elapsed_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [LED_W-1:0]     out_led;
    logic [HUE_W-1:0]     out_hue;
    logic [LVL_W-1:0]     out_level;
    logic                 finished;

    envelope_scoreboard sb = new();
    bit steady_in  = 1'b0;
    bit steady_out = 1'b0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    led_fade_envelope dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elapsed_ms (elapsed_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_led    (out_led),
        .out_hue    (out_hue),
        .out_level  (out_level),
        .finished   (finished)
    );

    // check writes, note accepted items, watch for a hung block
    always @(posedge clk)
    begin : monitor
        led_write_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.led   = out_led;
            got.hue   = out_hue;
            got.level = out_level;
            got.fin   = finished;
            sb.check_result(got);
        end
        if (rst_n && in_valid && !in_stall)
            sb.note_item(elapsed_ms);
        if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall per write, with stretches of none
    initial
    begin : receiver
        int stall_len;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                steady_out = !steady_out;
            stall_len = steady_out ? 0 : $urandom_range(0, 9);
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (stall_len - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [TIME_W-1:0] now);
        int gap;
        if ($urandom_range(0, 39) == 0)
            steady_in = !steady_in;
        gap = steady_in ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_ms <= now;
        do @(posedge clk); while (in_stall);
    endtask

    // stop offering, wait for every write due, then let the pipe empty
    task automatic end_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all registers back to back, plus the unused index
    task automatic apply_settings(input logic [CFG_W-1:0] off, rise, hold, fall,
                                  input logic [CFG_W-1:0] peak, hue, led);
        logic [CFG_W-1:0] vals [8];
        vals[CFG_OFFSET] = off;
        vals[CFG_RISE]   = rise;
        vals[CFG_HOLD]   = hold;
        vals[CFG_FALL]   = fall;
        vals[CFG_PEAK]   = peak;
        vals[CFG_HUE]    = hue;
        vals[CFG_LED]    = led;
        vals[CFG_SPARE]  = CFG_W'($urandom);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(i[CFG_IDX_W-1:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [MS_W-1:0] draw_ms();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 50)
            return MS_W'($urandom_range(1, 12));
        return MS_W'($urandom_range(1, 2000));
    endfunction

    function automatic logic [MS_W-1:0] draw_offset();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return '0;
        if (roll < 50)
            return '1;
        return MS_W'($urandom_range(1, 3000));
    endfunction

    function automatic logic [LVL_W-1:0] draw_peak();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return 16'h8000;
        if (roll < 40)
            return 16'hFFFF;
        if (roll < 55)
            return LVL_W'($urandom_range(32769, 65535));
        return LVL_W'($urandom_range(0, 32768));
    endfunction

    // mostly times inside the envelope, some near phase borders, some before the offset, some anywhere
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned roll;
        int unsigned span;
        logic [TIME_W-1:0] mark;
        logic [TIME_W-1:0] base;
        base = TIME_W'(sb.offset_ms);
        span = TIME_W'(sb.rise_ms) + TIME_W'(sb.hold_ms) + TIME_W'(sb.fall_ms);
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return base + $urandom_range(0, span + span / 8 + 2);
        if (roll < 75) begin
            case ($urandom_range(0, 3))
                0:       mark = base;
                1:       mark = base + TIME_W'(sb.rise_ms);
                2:       mark = base + TIME_W'(sb.rise_ms) + TIME_W'(sb.hold_ms);
                default: mark = base + span;
            endcase
            return mark + $urandom_range(0, 4) - 2;
        end
        if (roll < 85)
            return $urandom_range(0, base);
        return $urandom;
    endfunction

    initial
    begin : stimulus
        logic [TIME_W-1:0] now;
        int made;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_OFFSET;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        elapsed_ms <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: each phase, its borders, then sticky finish
        send_item(32'd0);
        send_item(32'd1);
        send_item(32'd200);
        send_item(32'd399);
        send_item(32'd400);
        send_item(32'd799);
        send_item(32'd800);
        send_item(32'd1000);
        send_item(32'd1199);
        send_item(32'd1200);
        send_item(32'hFFFF_FFFF);
        send_item(32'd100);
        end_phase();

        // largest offset, zero-length phases, largest peak
        apply_settings(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(32'd0);
        send_item(32'd65534);
        send_item(32'd65535);
        send_item(32'h8000_0000);
        end_phase();

        // longest rise and fall, no hold
        apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'h8000, 16'h5A5A, 16'h0081);
        send_item(32'd65534);
        send_item(32'd65535);
        send_item(32'd131069);
        send_item(32'd131070);
        send_item(32'd1);
        end_phase();

        // random settings, random times
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(draw_offset(), draw_ms(), draw_ms(), draw_ms(), draw_peak(),
                           CFG_W'($urandom), CFG_W'($urandom));
            made = 0;
            while (made < ITEMS_PER_PHASE) begin
                now = pick_time();
                made++;
                send_item(now);
            end
            end_phase();
        end

        if (sb.fails == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
